### rtl/core/vns_pkg.sv
// Shared types, constants and header decode for the VCL NAL unit scanner.
// No dependencies; used by every module of the block.
package vns_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic       vcl_found;
        logic [4:0] pic_type;
        logic       is_idr;
    } t_out_word;

    typedef struct packed {
        logic       vcl;
        logic [4:0] pic_type;
    } t_hdr;

    localparam logic       CODEC_HEVC     = 1'b0;
    localparam logic       CODEC_H264     = 1'b1;
    localparam logic [5:0] HEVC_TYPE_MASK = 6'h3F;
    localparam logic [4:0] H264_TYPE_MASK = 5'h1F;
    localparam logic [5:0] HEVC_VCL_LIMIT = 6'd32;
    localparam logic [4:0] H264_VCL_MIN   = 5'd1;
    localparam logic [4:0] H264_VCL_MAX   = 5'd12;
    localparam logic [4:0] HEVC_IDR_A     = 5'd19;
    localparam logic [4:0] HEVC_IDR_B     = 5'd20;
    localparam logic [4:0] H264_IDR       = 5'd5;
    localparam logic [2:0] SEEN_SAT       = 3'd4;
    localparam logic [2:0] SEEN_HDR       = 3'd3;
    localparam logic [1:0] PHASE_LAST     = 2'd3;

    function automatic t_hdr hdr_decode(input logic [7:0] b, input logic codec);
        t_hdr       h;
        logic [5:0] ty6;
        logic [4:0] ty5;
        ty6 = b[6:1] & HEVC_TYPE_MASK;
        ty5 = b[4:0] & H264_TYPE_MASK;
        if (codec == CODEC_HEVC) begin
            h.vcl      = ty6 < HEVC_VCL_LIMIT;
            h.pic_type = ty6[4:0];
        end else begin
            h.vcl      = (ty5 >= H264_VCL_MIN) && (ty5 <= H264_VCL_MAX);
            h.pic_type = ty5;
        end
        return h;
    endfunction

    function automatic logic idr_check(input logic [4:0] t, input logic codec);
        if (codec == CODEC_HEVC) begin
            return (t == HEVC_IDR_A) || (t == HEVC_IDR_B);
        end
        return t == H264_IDR;
    endfunction

endpackage

### rtl/core/vns_core.sv
// Per-packet scan state: start-code detection, start-code header scan and length-prefix walk.
// Depends on vns_pkg; instantiated by vcl_nal_unit_scanner_top.
module vns_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_codec,
    input  logic               i_step,
    input  vns_pkg::t_in_word  i_word,
    output vns_pkg::t_out_word o_result
);

    logic [23:0] r_recent,      n_recent;
    logic [2:0]  r_seen,        n_seen;
    logic        r_start_code,  n_start_code;
    logic        r_scan_found,  n_scan_found;
    logic [4:0]  r_scan_type,   n_scan_type;
    logic [1:0]  r_phase,       n_phase;
    logic [31:0] r_plen,        n_plen;
    logic [31:0] r_left,        n_left;
    logic        r_stopped,     n_stopped;
    logic        r_pfx_found,   n_pfx_found;
    logic [4:0]  r_pfx_type,    n_pfx_type;
    logic        r_unit_vcl,    n_unit_vcl;

    vns_pkg::t_hdr w_hdr;
    logic [7:0]    w_b;
    logic          w_found;
    logic [4:0]    w_type;

    always_comb begin
        w_b   = i_word.data_byte;
        w_hdr = vns_pkg::hdr_decode(w_b, i_codec);

        n_recent     = r_recent;
        n_seen       = r_seen;
        n_start_code = r_start_code;
        n_scan_found = r_scan_found;
        n_scan_type  = r_scan_type;
        n_phase      = r_phase;
        n_plen       = r_plen;
        n_left       = r_left;
        n_stopped    = r_stopped;
        n_pfx_found  = r_pfx_found;
        n_pfx_type   = r_pfx_type;
        n_unit_vcl   = r_unit_vcl;

        if (r_seen == vns_pkg::SEEN_HDR && r_recent[23:8] == 16'h0000 &&
            (r_recent[7:0] == 8'h01 || (r_recent[7:0] == 8'h00 && w_b == 8'h01))) begin
            n_start_code = 1'b1;
        end

        if (r_seen >= vns_pkg::SEEN_HDR && !r_scan_found && r_recent == 24'h000001 &&
            w_hdr.vcl) begin
            n_scan_found = 1'b1;
            n_scan_type  = w_hdr.pic_type;
        end

        if (!r_stopped && !r_pfx_found) begin
            if (r_left == 32'd0) begin
                n_plen = {r_plen[23:0], w_b};
                if (r_phase == vns_pkg::PHASE_LAST) begin
                    n_phase = 2'd0;
                    if (n_plen == 32'd0 || n_plen[31]) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_left = n_plen;
                    end
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end else begin
                if (r_left == r_plen) begin
                    n_unit_vcl = w_hdr.vcl;
                    if (w_hdr.vcl) begin
                        n_pfx_type = w_hdr.pic_type;
                    end
                end
                n_left = r_left - 32'd1;
                if (n_left == 32'd0) begin
                    if (n_unit_vcl) begin
                        n_pfx_found = 1'b1;
                    end
                    n_unit_vcl = 1'b0;
                end
            end
        end

        w_found = 1'b0;
        w_type  = 5'd0;
        if (r_seen >= vns_pkg::SEEN_HDR) begin
            w_found = n_start_code ? n_scan_found : n_pfx_found;
            w_type  = n_start_code ? n_scan_type  : n_pfx_type;
        end
        if (!w_found) begin
            w_type = 5'd0;
        end
        o_result.vcl_found = w_found;
        o_result.pic_type  = w_type;
        o_result.is_idr    = w_found && vns_pkg::idr_check(w_type, i_codec);

        if (i_word.last_byte) begin
            n_recent     = '0;
            n_seen       = '0;
            n_start_code = 1'b0;
            n_scan_found = 1'b0;
            n_scan_type  = '0;
            n_phase      = '0;
            n_plen       = '0;
            n_left       = '0;
            n_stopped    = 1'b0;
            n_pfx_found  = 1'b0;
            n_pfx_type   = '0;
            n_unit_vcl   = 1'b0;
        end else begin
            n_recent = {r_recent[15:0], w_b};
            if (r_seen < vns_pkg::SEEN_SAT) begin
                n_seen = r_seen + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent     <= '0;
            r_seen       <= '0;
            r_start_code <= 1'b0;
            r_scan_found <= 1'b0;
            r_scan_type  <= '0;
            r_phase      <= '0;
            r_plen       <= '0;
            r_left       <= '0;
            r_stopped    <= 1'b0;
            r_pfx_found  <= 1'b0;
            r_pfx_type   <= '0;
            r_unit_vcl   <= 1'b0;
        end else if (i_step) begin
            r_recent     <= n_recent;
            r_seen       <= n_seen;
            r_start_code <= n_start_code;
            r_scan_found <= n_scan_found;
            r_scan_type  <= n_scan_type;
            r_phase      <= n_phase;
            r_plen       <= n_plen;
            r_left       <= n_left;
            r_stopped    <= n_stopped;
            r_pfx_found  <= n_pfx_found;
            r_pfx_type   <= n_pfx_type;
            r_unit_vcl   <= n_unit_vcl;
        end
    end

endmodule

### rtl/core/vcl_nal_unit_scanner_top.sv
// Input words are registered; a last byte's result is registered for output.
// Throughput: one byte per cycle; only a last byte waits, on a full, stalled output.
// Reset (synchronous, active low) clears the codec register, packet state and both valids.
// Top level of the VCL NAL unit scanner: input register, vns_core, result register.
// Depends on vns_pkg and vns_core.
module vcl_nal_unit_scanner_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vns_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vns_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    logic               r_codec;
    logic               r_in_valid;
    vns_pkg::t_in_word  r_in;
    logic               r_out_valid;
    vns_pkg::t_out_word r_out;
    vns_pkg::t_out_word w_result;
    logic               w_out_free;
    logic               w_step;
    logic               w_accept;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && (!r_in.last_byte || w_out_free);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_accept   = i_in_valid && !o_in_stall;

    vns_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_codec  (r_codec),
        .i_step   (w_step),
        .i_word   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec     <= vns_pkg::CODEC_HEVC;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_codec <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_in <= i_in_word;
        end
        if (w_step && r_in.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/core/vns_checker.sv
// Port-level checks for vcl_nal_unit_scanner_top, attached by bind.
// Depends on vns_pkg.
module vns_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input vns_pkg::t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("valid or stall set after reset");

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.vcl_found |->
            o_out_word.pic_type == 5'd0 && !o_out_word.is_idr)
        else $error("nonzero type or idr without a found picture");

    a_idr_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.is_idr |->
            o_out_word.pic_type == vns_pkg::HEVC_IDR_A ||
            o_out_word.pic_type == vns_pkg::HEVC_IDR_B ||
            o_out_word.pic_type == vns_pkg::H264_IDR)
        else $error("idr flag on a non-idr type");

endmodule

bind vcl_nal_unit_scanner_top vns_checker u_vns_checker (.*);
